// File: rtl/deadzone_pid_position_tracker_top_macros.svh
// Assertion macros shared by the deadzone PID tracker checker.
`ifndef DEADZONE_PID_POSITION_TRACKER_TOP_MACROS_SVH
`define DEADZONE_PID_POSITION_TRACKER_TOP_MACROS_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define DZPID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dzpid: next-cycle check failed");

// Antecedent implies consequent in the same cycle.
`define DZPID_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dzpid: same-cycle check failed");

`endif

// File: rtl/dzpid_pkg.sv
// Shared types, constants and microcode table of the deadzone PID tracker.
`default_nettype none

package dzpid_pkg;

    localparam int POSITION_INIT_DEF = 700;
    localparam int FRAC_BITS_DEF     = 8;

    localparam int GAIN_FRAC   = 12;
    localparam int DECAY_SHIFT = 16;
    localparam int INTEG_W     = 20;
    localparam int ERR_W       = 16;
    localparam int POS_INT_W   = 12;
    localparam int STEP_W      = 22;
    localparam int COEF_W      = 17;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 5;
    localparam int PC_W        = 4;

    // 0.95 in Q0.16
    localparam logic signed [COEF_W-1:0] DECAY_Q16 = 17'sd62259;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_LOAD   = 2'd2,
        OP_RSVD   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_DRIVE_MAX  = 3'd3,
        REG_DRIVE_MIN  = 3'd4,
        REG_DEADZONE   = 3'd5,
        REG_POS_FLOOR  = 3'd6,
        REG_POS_CEIL   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [15:0] prop_gain;
        logic signed [15:0] integ_gain;
        logic signed [15:0] deriv_gain;
        logic signed [13:0] drive_max;
        logic signed [13:0] drive_min;
        logic        [14:0] error_deadzone;
        logic        [11:0] position_floor;
        logic        [11:0] position_ceiling;
    } t_cfg;

    localparam t_cfg CFG_RST = '{
        prop_gain:        -16'sd1229,
        integ_gain:       16'sd0,
        deriv_gain:       16'sd0,
        drive_max:        14'sd5000,
        drive_min:        -14'sd5000,
        error_deadzone:   15'd5,
        position_floor:   12'd0,
        position_ceiling: 12'd4095
    };

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_RUN  = 2'b10
    } t_seq_state;

    typedef enum logic [2:0] {
        MUL_NONE  = 3'd0,
        MUL_DECAY = 3'd1,
        MUL_PROP  = 3'd2,
        MUL_INTEG = 3'd3,
        MUL_DERIV = 3'd4
    } t_mul_sel;

    typedef enum logic [3:0] {
        ALU_NOP        = 4'd0,
        ALU_PREP       = 4'd1,
        ALU_INTEG      = 4'd2,
        ALU_STEP_P     = 4'd3,
        ALU_STEP_I     = 4'd4,
        ALU_STEP_D     = 4'd5,
        ALU_STEP_CLAMP = 4'd6,
        ALU_POS_ADD    = 4'd7,
        ALU_POS_CLAMP  = 4'd8,
        ALU_SPECIAL    = 4'd9
    } t_alu_op;

    typedef enum logic [1:0] {
        COND_NEVER  = 2'd0,
        COND_ALWAYS = 2'd1,
        COND_OP_NZ  = 2'd2
    } t_cond;

    typedef struct packed {
        t_mul_sel        mul;
        t_alu_op         alu;
        t_cond           cond;
        logic [PC_W-1:0] target;
        logic            emit;
    } t_uword;

    typedef struct packed {
        logic   accept;
        logic   exec;
        t_uword uw;
    } t_dp_ctl;

    typedef struct packed {
        logic op_nz;
    } t_dp_flags;

    localparam logic [PC_W-1:0] UPC_ENTRY   = 4'd0;
    localparam logic [PC_W-1:0] UPC_INTEG   = 4'd1;
    localparam logic [PC_W-1:0] UPC_TERM_P  = 4'd2;
    localparam logic [PC_W-1:0] UPC_TERM_I  = 4'd3;
    localparam logic [PC_W-1:0] UPC_TERM_D  = 4'd4;
    localparam logic [PC_W-1:0] UPC_CLAMP   = 4'd5;
    localparam logic [PC_W-1:0] UPC_POS_ADD = 4'd6;
    localparam logic [PC_W-1:0] UPC_POS_LIM = 4'd7;
    localparam logic [PC_W-1:0] UPC_EMIT    = 4'd8;
    localparam logic [PC_W-1:0] UPC_SPECIAL = 4'd9;

    // Microprogram. Each word: multiplier operands, ALU op, jump, emit.
    function automatic t_uword ucode_word(input logic [PC_W-1:0] pc);
        t_uword w;
        w.mul    = MUL_NONE;
        w.alu    = ALU_NOP;
        w.cond   = COND_NEVER;
        w.target = UPC_ENTRY;
        w.emit   = 1'b0;
        case (pc)
            UPC_ENTRY: begin
                w.mul    = MUL_DECAY;
                w.alu    = ALU_PREP;
                w.cond   = COND_OP_NZ;
                w.target = UPC_SPECIAL;
            end
            UPC_INTEG: begin
                w.mul = MUL_PROP;
                w.alu = ALU_INTEG;
            end
            UPC_TERM_P: begin
                w.mul = MUL_INTEG;
                w.alu = ALU_STEP_P;
            end
            UPC_TERM_I: begin
                w.mul = MUL_DERIV;
                w.alu = ALU_STEP_I;
            end
            UPC_TERM_D:  w.alu = ALU_STEP_D;
            UPC_CLAMP:   w.alu = ALU_STEP_CLAMP;
            UPC_POS_ADD: w.alu = ALU_POS_ADD;
            UPC_POS_LIM: w.alu = ALU_POS_CLAMP;
            UPC_EMIT:    w.emit = 1'b1;
            UPC_SPECIAL: begin
                w.alu    = ALU_SPECIAL;
                w.cond   = COND_ALWAYS;
                w.target = UPC_EMIT;
            end
            default:     w.emit = 1'b1;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dzpid_regs.sv
// APB configuration register file of the deadzone PID tracker.
`default_nettype none

module dzpid_regs import dzpid_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (wr) begin
            case (idx)
                REG_PROP_GAIN:  r_cfg.prop_gain        <= pwdata[15:0];
                REG_INTEG_GAIN: r_cfg.integ_gain       <= pwdata[15:0];
                REG_DERIV_GAIN: r_cfg.deriv_gain       <= pwdata[15:0];
                REG_DRIVE_MAX:  r_cfg.drive_max        <= pwdata[13:0];
                REG_DRIVE_MIN:  r_cfg.drive_min        <= pwdata[13:0];
                REG_DEADZONE:   r_cfg.error_deadzone   <= pwdata[14:0];
                REG_POS_FLOOR:  r_cfg.position_floor   <= pwdata[11:0];
                REG_POS_CEIL:   r_cfg.position_ceiling <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PROP_GAIN:  prdata = {16'd0, r_cfg.prop_gain};
            REG_INTEG_GAIN: prdata = {16'd0, r_cfg.integ_gain};
            REG_DERIV_GAIN: prdata = {16'd0, r_cfg.deriv_gain};
            REG_DRIVE_MAX:  prdata = {18'd0, r_cfg.drive_max};
            REG_DRIVE_MIN:  prdata = {18'd0, r_cfg.drive_min};
            REG_DEADZONE:   prdata = {17'd0, r_cfg.error_deadzone};
            REG_POS_FLOOR:  prdata = {20'd0, r_cfg.position_floor};
            REG_POS_CEIL:   prdata = {20'd0, r_cfg.position_ceiling};
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/dzpid_seq.sv
// Microcode sequencer: step counter, jumps, input and output handshake.
`default_nettype none

module dzpid_seq import dzpid_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_dp_flags i_flags,
    output t_dp_ctl   o_ctl
);

    t_seq_state      r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_out_valid, n_out_valid;
    t_uword          uw;
    logic            slot_free;
    logic            accept;
    logic            exec;
    logic            take_jump;

    always_comb begin
        uw        = ucode_word(r_pc);
        slot_free = !r_out_valid || i_out_ready;
        accept    = (r_state == SEQ_IDLE) && i_in_valid;
        // emit step waits for a free output slot
        exec      = (r_state == SEQ_RUN) && (!uw.emit || slot_free);

        case (uw.cond)
            COND_ALWAYS: take_jump = 1'b1;
            COND_OP_NZ:  take_jump = i_flags.op_nz;
            default:     take_jump = 1'b0;
        endcase

        n_state     = r_state;
        n_pc        = r_pc;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            SEQ_IDLE: begin
                if (accept) begin
                    n_state = SEQ_RUN;
                    n_pc    = UPC_ENTRY;
                end
            end
            SEQ_RUN: begin
                if (exec) begin
                    if (uw.emit) begin
                        n_state     = SEQ_IDLE;
                        n_out_valid = 1'b1;
                    end else if (take_jump) begin
                        n_pc = uw.target;
                    end else begin
                        n_pc = r_pc + 1'b1;
                    end
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_pc        <= UPC_ENTRY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == SEQ_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_ctl       = '{accept: accept, exec: exec, uw: uw};

endmodule

`default_nettype wire

// File: rtl/dzpid_dp.sv
// Datapath: shared multiplier, accumulator, PID state and limit logic.
`default_nettype none

module dzpid_dp import dzpid_pkg::*; #(
    parameter int POSITION_INIT = POSITION_INIT_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cfg                        i_cfg,
    input  t_dp_ctl                     i_ctl,
    input  t_opcode                     i_opcode,
    input  logic signed [ERR_W-1:0]     i_error_sample,
    input  logic [POS_INT_W-1:0]        i_load_position,
    output logic [POS_INT_W-1:0]        o_position,
    output logic signed [STEP_W-1:0]    o_drive_step,
    output t_dp_flags                   o_flags
);

    localparam int ACC_W  = (FRAC_BITS + 30 > 38) ? FRAC_BITS + 30 : 38;
    localparam int POS_W  = POS_INT_W + FRAC_BITS;
    localparam int MUL_W  = INTEG_W + COEF_W;
    localparam int SH_R   = (FRAC_BITS <= GAIN_FRAC) ? GAIN_FRAC - FRAC_BITS : 0;
    localparam int SH_L   = (FRAC_BITS > GAIN_FRAC) ? FRAC_BITS - GAIN_FRAC : 0;
    localparam int RECIP_SH = 18;
    localparam logic [15:0] RECIP5 = 16'd52429;   // ceil(2^18 / 5)

    typedef logic signed [ACC_W-1:0] t_acc;

    localparam t_acc REM_1  = t_acc'((1 << FRAC_BITS) / 5);
    localparam t_acc REM_2  = t_acc'((2 << FRAC_BITS) / 5);
    localparam t_acc REM_3  = t_acc'((3 << FRAC_BITS) / 5);
    localparam t_acc REM_4  = t_acc'((4 << FRAC_BITS) / 5);
    localparam t_acc INT_HI = t_acc'((1 << (INTEG_W - 1)) - 1);
    localparam t_acc INT_LO = t_acc'(-(1 << (INTEG_W - 1)));
    localparam logic [POS_W-1:0] POS_RST = POS_W'(POSITION_INIT << FRAC_BITS);

    // arithmetic shift right, rounding toward zero
    function automatic t_acc trunc0(input t_acc p, input int unsigned sh);
        t_acc bias;
        bias = p[ACC_W-1] ? ((t_acc'(1) <<< sh) - t_acc'(1)) : t_acc'(0);
        return (p + bias) >>> sh;
    endfunction

    // gain product (Q12 times integer) rescaled to F fraction bits
    function automatic t_acc scale_g(input t_acc p);
        return trunc0(p, SH_R) <<< SH_L;
    endfunction

    function automatic t_acc clamp2(input t_acc v, input t_acc hi, input t_acc lo);
        if (v > hi)      return hi;
        else if (v < lo) return lo;
        else             return v;
    endfunction

    function automatic t_acc sat_integ(input t_acc v);
        if (v > INT_HI)      return INT_HI;
        else if (v < INT_LO) return INT_LO;
        else                 return v;
    endfunction

    function automatic t_acc rem_frac(input logic [2:0] r);
        case (r)
            3'd1:    return REM_1;
            3'd2:    return REM_2;
            3'd3:    return REM_3;
            3'd4:    return REM_4;
            default: return t_acc'(0);
        endcase
    endfunction

    // architectural state
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_last;
    logic [POS_W-1:0]          r_pos;

    // working registers
    t_opcode                   r_op;
    logic signed [ERR_W-1:0]   r_err;
    logic [POS_INT_W-1:0]      r_load;
    logic signed [ERR_W:0]     r_diff;
    logic signed [MUL_W-1:0]   r_prod;
    t_acc                      r_tmp;
    t_acc                      r_step;
    logic [POS_INT_W-1:0]      r_out_pos;
    logic signed [STEP_W-1:0]  r_out_step;

    // integral limits, drive*2^F/5 toward zero, two register stages
    logic signed [13:0] lim_src [2];
    logic [13:0]        lim_mag [2];
    logic [29:0]        lim_prod [2];
    logic [10:0]        lim_q [2];
    logic [2:0]         lim_r [2];
    logic [10:0]        r_lim_q [2];
    logic [2:0]         r_lim_r [2];
    logic               r_lim_neg [2];
    t_acc               lim_abs [2];
    t_acc               r_lim [2];

    logic signed [MUL_W-1:0]   mul_p;
    logic signed [INTEG_W-1:0] mul_a;
    logic signed [COEF_W-1:0]  mul_b;
    logic signed [ERR_W:0]     err_ext;
    logic [ERR_W:0]            err_mag;
    logic                      dz_hit;
    t_acc                      prod_x;
    t_acc                      integ_new;
    t_acc                      step_hi, step_lo;
    t_acc                      pos_lo, pos_hi, pos_t1, pos_t2;

    always_comb begin
        lim_src[0] = i_cfg.drive_max;
        lim_src[1] = i_cfg.drive_min;
        for (int i = 0; i < 2; i++) begin
            lim_mag[i]  = lim_src[i][13] ? 14'(-lim_src[i]) : 14'(lim_src[i]);
            lim_prod[i] = lim_mag[i] * RECIP5;
            lim_q[i]    = lim_prod[i][RECIP_SH +: 11];
            lim_r[i]    = 3'(lim_mag[i] - 14'(14'(lim_q[i]) * 14'd5));
            lim_abs[i]  = (t_acc'(r_lim_q[i]) <<< FRAC_BITS) + rem_frac(r_lim_r[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            r_lim_q[i]   <= lim_q[i];
            r_lim_r[i]   <= lim_r[i];
            r_lim_neg[i] <= lim_src[i][13];
            r_lim[i]     <= r_lim_neg[i] ? -lim_abs[i] : lim_abs[i];
        end
    end

    always_comb begin
        case (i_ctl.uw.mul)
            MUL_DECAY: begin
                mul_a = r_integ;
                mul_b = DECAY_Q16;
            end
            MUL_PROP: begin
                mul_a = INTEG_W'(r_err);
                mul_b = COEF_W'(i_cfg.prop_gain);
            end
            MUL_INTEG: begin
                mul_a = r_integ;
                mul_b = COEF_W'(i_cfg.integ_gain);
            end
            MUL_DERIV: begin
                mul_a = INTEG_W'(r_diff);
                mul_b = COEF_W'(i_cfg.deriv_gain);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;

        err_ext = (ERR_W+1)'(r_err);
        err_mag = err_ext[ERR_W] ? unsigned'(-err_ext) : unsigned'(err_ext);
        dz_hit  = err_mag > {2'b00, i_cfg.error_deadzone};

        prod_x    = t_acc'(r_prod);
        integ_new = dz_hit ? sat_integ(clamp2(r_tmp, r_lim[0], r_lim[1]))
                           : sat_integ(trunc0(prod_x, DECAY_SHIFT));

        step_hi = t_acc'(i_cfg.drive_max) <<< FRAC_BITS;
        step_lo = t_acc'(i_cfg.drive_min) <<< FRAC_BITS;

        // floor first, ceiling last so the ceiling wins when crossed
        pos_lo = t_acc'(i_cfg.position_floor) <<< FRAC_BITS;
        pos_hi = t_acc'(i_cfg.position_ceiling) <<< FRAC_BITS;
        pos_t1 = (r_tmp < pos_lo) ? pos_lo : r_tmp;
        pos_t2 = (pos_t1 > pos_hi) ? pos_hi : pos_t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
            r_pos   <= POS_RST;
        end else if (i_ctl.exec) begin
            case (i_ctl.uw.alu)
                ALU_INTEG:      r_integ <= integ_new[INTEG_W-1:0];
                ALU_STEP_CLAMP: r_last  <= r_err;
                ALU_POS_CLAMP:  r_pos   <= pos_t2[POS_W-1:0];
                ALU_SPECIAL: begin
                    case (r_op)
                        OP_CLEAR: begin
                            r_integ <= '0;
                            r_last  <= '0;
                        end
                        OP_LOAD: r_pos <= {r_load, {FRAC_BITS{1'b0}}};
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_op   <= i_opcode;
            r_err  <= i_error_sample;
            r_load <= i_load_position;
        end
        if (i_ctl.exec) begin
            if (i_ctl.uw.mul != MUL_NONE) begin
                r_prod <= mul_p;
            end
            case (i_ctl.uw.alu)
                ALU_PREP: begin
                    r_tmp  <= t_acc'(r_integ) + (t_acc'(r_err) <<< FRAC_BITS);
                    r_diff <= (ERR_W+1)'(r_err) - (ERR_W+1)'(r_last);
                end
                ALU_STEP_P:     r_step <= scale_g(prod_x);
                ALU_STEP_I:     r_step <= r_step + trunc0(prod_x, GAIN_FRAC);
                ALU_STEP_D:     r_step <= r_step + scale_g(prod_x);
                ALU_STEP_CLAMP: r_step <= clamp2(r_step, step_hi, step_lo);
                ALU_POS_ADD:    r_tmp  <= t_acc'(r_pos) + r_step;
                ALU_SPECIAL:    r_step <= '0;
                default: ;
            endcase
            if (i_ctl.uw.emit) begin
                r_out_pos  <= r_pos[FRAC_BITS +: POS_INT_W];
                r_out_step <= r_step[STEP_W-1:0];
            end
        end
    end

    assign o_position   = r_out_pos;
    assign o_drive_step = r_out_step;
    assign o_flags      = '{op_nz: (r_op != OP_SAMPLE)};

endmodule

`default_nettype wire

// File: rtl/deadzone_pid_position_tracker_top.sv
// Deadzone PID position tracker, top level: stream ports, APB config, sequencer, datapath.
// An error sample walks every microprogram step from acceptance to the emit step that raises
// m_tvalid; clear/load/unused words jump to the special step, then emit. One word is in flight
//   at a time, on a single shared 20x17 multiplier and one accumulator.
// Output stall holds the emit step; the next input word is taken while a result waits.
// Reset (synchronous, i_rst_n low) sets registers to defaults, integral and last error
//   to zero, position to POSITION_INIT; integral limits settle through registers after a config write.
`default_nettype none

module deadzone_pid_position_tracker_top import dzpid_pkg::*; #(
    parameter int POSITION_INIT = POSITION_INIT_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [15:0] error_sample, [27:16] load_position
    input  logic [1:0]             i_s_tuser,   // [1:0] opcode
    // result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [11:0] position, [33:12] drive_step
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    t_cfg                     cfg;
    t_dp_ctl                  ctl;
    t_dp_flags                flags;
    logic [POS_INT_W-1:0]     position;
    logic signed [STEP_W-1:0] drive_step;

    dzpid_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // step counter and handshake; one word in flight at a time
    dzpid_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_flags     (flags),
        .o_ctl       (ctl)
    );

    // multiplier, accumulator and PID state driven by the control word
    dzpid_dp #(
        .POSITION_INIT (POSITION_INIT),
        .FRAC_BITS     (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_ctl           (ctl),
        .i_opcode        (t_opcode'(i_s_tuser)),
        .i_error_sample  (i_s_tdata[ERR_W-1:0]),
        .i_load_position (i_s_tdata[ERR_W +: POS_INT_W]),
        .o_position      (position),
        .o_drive_step    (drive_step),
        .o_flags         (flags)
    );

    // pad to whole bytes
    assign o_m_tdata = {{(OUT_TDATA_W - POS_INT_W - STEP_W){1'b0}}, drive_step, position};

endmodule

`default_nettype wire

// File: rtl/dzpid_chk.sv
// Port-level checker for the deadzone PID tracker, bound to the top level.
`default_nettype none

`include "deadzone_pid_position_tracker_top_macros.svh"

module dzpid_chk import dzpid_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    // a pending result stays offered until taken
    `DZPID_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)
    // and its word does not change meanwhile
    `DZPID_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, $stable(o_m_tdata))
    // one word in flight: input closes right after an acceptance
    `DZPID_ASSERT_NEXT(a_one_inflight, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    // a new result only comes out of a busy sequencer
    `DZPID_ASSERT_NOW(a_result_from_busy, i_clk, i_rst_n, $rose(o_m_tvalid), $past(!o_s_tready))

endmodule

bind deadzone_pid_position_tracker_top dzpid_chk u_chk (.*);

`default_nettype wire
